[hdl/pgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_pkg
// Types and codes shared by the priority group dispatcher and its table cells.
// ----------------------------------------------------------------------------
package pgd_pkg;

  // Wide enough for an entry count of up to 64.
  localparam int CNT_W = 7;
  localparam int MASK_W = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_STEP = 2'd2;
  // The spare request code behaves as a step.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_BAD_CAT = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DISPATCHED = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  typedef struct packed {
    logic [15:0] handle;
    logic [2:0] category;
    logic signed [15:0] priority_val;
    logic keep;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_SHIFT
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic [CNT_W-1:0] count;
    logic app_en;
    logic [CNT_W-1:0] app_idx;
  } cell_ctl_t;

endpackage

[hdl/pgd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_cell
// One slot of the ordered table: holds an entry, takes part in an ordered
// insert and in the forward shift used by remove and step walks.
// ----------------------------------------------------------------------------
module pgd_cell import pgd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    head,
  input  entry_t    prev_data,
  input  logic      prev_ge,
  input  entry_t    succ_data,
  output logic      ge,
  output entry_t    data
);

  entry_t data_next;

  // Valid slots are sorted, so ge is high on a prefix of the chain.
  assign ge = (CNT_W'(IDX) < ctl.count) && (data.priority_val >= new_entry.priority_val);

  always_comb begin
    data_next = data;
    case (ctl.mode)
      MODE_INSERT: begin
        if (!ge) begin
          data_next = prev_ge ? new_entry : prev_data;
        end
      end
      MODE_SHIFT: begin
        if (ctl.app_en && ctl.app_idx == CNT_W'(IDX)) begin
          data_next = head;
        end else begin
          data_next = succ_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[hdl/priority_group_dispatcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_group_dispatcher
// Ordered task table with grouped dispatch, built as a chain of cells.
// ----------------------------------------------------------------------------
// On an insert every cell compares its priority with the new one and the
// tail of the chain moves back one place. A remove or a step walks the
// chain, one entry per cycle unless a step walk stalls, and a remove then
// answers once the output slot is free. Each walk step moves the head entry
// out of cell 0 and writes it back behind the entries still to be visited,
// or drops it. A step emits one result per entry and stalls while the output
// register is held. Bad category, full, empty step and an empty remove answer
// at once. A new request is taken only after the previous walk has ended.
// ----------------------------------------------------------------------------
module priority_group_dispatcher import pgd_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int CATEGORY_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] task_handle,
  input  logic [2:0]  task_category,
  input  logic signed [15:0] task_priority,
  input  logic        keep_after_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [2:0]  out_category,
  output logic [3:0]  group_number,
  output logic        group_start,
  output logic        last_result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REPLY
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] occ;
  logic [CNT_W-1:0] done_cnt;
  logic is_step;
  logic found;
  logic [15:0] key;
  logic [MASK_W-1:0] used;
  logic [3:0] grp;

  entry_t new_entry;
  entry_t cell_data [TABLE_DEPTH];
  logic cell_ge [TABLE_DEPTH];
  cell_ctl_t ctl;

  logic slot_free, in_acc, load;
  logic [2:0] ld_status;
  logic [15:0] ld_handle;
  logic [2:0] ld_cat;
  logic [3:0] ld_grp;
  logic ld_start, ld_last;
  logic bad_cat, full, walk_go, head_keep, hit, last_walk, repeat_cat;
  logic [MASK_W-1:0] cat_bit;
  entry_t head;

  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && slot_free;
  assign in_acc = in_valid && in_ready;
  assign head = cell_data[0];

  assign new_entry.handle = task_handle;
  assign new_entry.category = task_category;
  assign new_entry.priority_val = task_priority;
  assign new_entry.keep = keep_after_step;

  assign bad_cat = 32'(task_category) >= 32'(CATEGORY_COUNT);
  assign full = 32'(count) >= 32'(TABLE_DEPTH);
  assign cat_bit = MASK_W'(1) << head.category;
  assign repeat_cat = (done_cnt != '0) && ((used & cat_bit) != '0);
  assign hit = !is_step && !found && (head.handle == key);
  assign head_keep = is_step ? head.keep : !hit;
  assign last_walk = (done_cnt + CNT_W'(1)) == count;
  // A remove walk never waits on the output; a step walk needs a free slot.
  assign walk_go = (state == S_WALK) && (!is_step || slot_free);

  always_comb begin
    ctl.mode = MODE_HOLD;
    ctl.count = count;
    ctl.app_en = head_keep;
    ctl.app_idx = occ - CNT_W'(1);
    if (in_acc && req_type == REQ_INSERT && !bad_cat && !full) begin
      ctl.mode = MODE_INSERT;
    end else if (walk_go) begin
      ctl.mode = MODE_SHIFT;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pgd_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_entry (new_entry),
      .head      (head),
      .prev_data ((i == 0) ? new_entry : cell_data[(i == 0) ? 0 : i - 1]),
      .prev_ge   ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
      .succ_data (cell_data[(i == TABLE_DEPTH - 1) ? i : i + 1]),
      .ge        (cell_ge[i]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    load = 1'b0;
    ld_status = ST_INSERTED;
    ld_handle = '0;
    ld_cat = '0;
    ld_grp = '0;
    ld_start = 1'b0;
    ld_last = 1'b1;
    if (in_acc) begin
      case (req_type)
        REQ_INSERT: begin
          load = 1'b1;
          ld_status = bad_cat ? ST_BAD_CAT : (full ? ST_FULL : ST_INSERTED);
        end
        REQ_REMOVE: begin
          load = (count == '0);
          ld_status = ST_NOT_FOUND;
        end
        default: begin
          load = (count == '0);
          ld_status = ST_EMPTY;
        end
      endcase
    end else if (walk_go && is_step) begin
      load = 1'b1;
      ld_status = ST_DISPATCHED;
      ld_handle = head.handle;
      ld_cat = head.category;
      ld_grp = (repeat_cat) ? grp + 4'd1 : grp;
      ld_start = (done_cnt == '0) || repeat_cat;
      ld_last = last_walk;
    end else if (state == S_REPLY && slot_free) begin
      load = 1'b1;
      ld_status = found ? ST_REMOVED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      occ <= '0;
      done_cnt <= '0;
      is_step <= 1'b0;
      found <= 1'b0;
      used <= '0;
      grp <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (req_type == REQ_INSERT) begin
              if (!bad_cat && !full) begin
                count <= count + CNT_W'(1);
              end
            end else if (count != '0) begin
              state <= S_WALK;
              is_step <= (req_type != REQ_REMOVE);
              occ <= count;
              done_cnt <= '0;
              found <= 1'b0;
              used <= '0;
              grp <= '0;
            end
          end
        end
        S_WALK: begin
          if (walk_go) begin
            done_cnt <= done_cnt + CNT_W'(1);
            if (!head_keep) begin
              occ <= occ - CNT_W'(1);
            end
            if (hit) begin
              found <= 1'b1;
            end
            if (is_step) begin
              used <= repeat_cat ? cat_bit : (used | cat_bit);
              grp <= ld_grp;
            end
            if (last_walk) begin
              count <= head_keep ? occ : occ - CNT_W'(1);
              state <= is_step ? S_IDLE : S_REPLY;
            end
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key <= task_handle;
    end
    if (load) begin
      status <= ld_status;
      out_handle <= ld_handle;
      out_category <= ld_cat;
      group_number <= ld_grp;
      group_start <= ld_start;
      last_result <= ld_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_occ_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (occ <= count) && (occ != '0) && (done_cnt < count))
    else $error("walk bookkeeping out of range");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.mode == MODE_INSERT |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_group_step: assert property (@(posedge clk) disable iff (rst)
    load && ld_status == ST_DISPATCHED && !ld_start |-> ld_grp == grp)
    else $error("group number changed without a group start");

endmodule
